// ----- rtl/rar_pkg.sv -----
package rar_pkg;

  localparam int SUM_NUM_W = 32;
  localparam int SUM_DEN_W = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ABS,
    ST_STRIP,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } rar_state_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_ABS,
    DP_STRIP,
    DP_ZERO,
    DP_SAVE,
    DP_GCD,
    DP_DIVN,
    DP_DIVD,
    DP_OUT
  } rar_op_t;

  typedef struct packed {
    rar_op_t op;
    logic    div_clr;
  } rar_cmd_t;

  typedef struct packed {
    logic u_zero;
    logic both_even;
    logic gcd_eq;
    logic g_one;
    logic n_last;
    logic d_last;
  } rar_sts_t;

endpackage

// ----- rtl/rar_ctrl.sv -----
module rar_ctrl
  import rar_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rar_sts_t sts,
  output rar_cmd_t cmd
);

  rar_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = DP_IDLE;
    cmd.div_clr   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd.op    = DP_MUL0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.op    = DP_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op    = DP_MUL2;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.op    = DP_ABS;
        state_nxt = ST_STRIP;
      end
      ST_STRIP: begin
        if (sts.u_zero) begin
          cmd.op    = DP_ZERO;
          state_nxt = ST_DONE;
        end else if (sts.both_even) begin
          cmd.op = DP_STRIP;
        end else begin
          cmd.op    = DP_SAVE;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts.gcd_eq) begin
          state_nxt = sts.g_one ? ST_DONE : ST_DIVN;
        end else begin
          cmd.op = DP_GCD;
        end
      end
      ST_DIVN: begin
        cmd.op = DP_DIVN;
        if (sts.n_last) begin
          cmd.div_clr = 1'b1;
          state_nxt   = ST_DIVD;
        end
      end
      ST_DIVD: begin
        cmd.op = DP_DIVD;
        if (sts.d_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/rar_dp.sv -----
module rar_dp
  import rar_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic        [OPERAND_WIDTH-2:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic        [OPERAND_WIDTH-2:0] in_b_den,
  input  rar_cmd_t                        cmd,
  output rar_sts_t                        sts,
  output logic signed [SUM_NUM_W-1:0]     out_sum_num,
  output logic        [SUM_DEN_W-1:0]     out_sum_den
);

  localparam int W   = OPERAND_WIDTH;
  localparam int NW  = 2 * W;
  localparam int DW  = NW - 2;
  localparam int CW  = $clog2(NW);
  localparam int XW  = (NW + 1 > SUM_NUM_W) ? NW + 1 : SUM_NUM_W;
  localparam int DXW = (DW > SUM_DEN_W) ? DW : SUM_DEN_W;

  logic signed [W-1:0]    an_r, bn_r;
  logic        [W-2:0]    ad_r, bd_r;
  logic signed [NW-1:0]   prod_r, top_r;
  logic                   neg_r;
  logic        [NW-1:0]   u_r, n_r;
  logic        [DW-1:0]   v_r, d_r, rem_r;
  logic        [CW-1:0]   cnt_r;
  logic signed [SUM_NUM_W-1:0] sum_num_r;
  logic        [SUM_DEN_W-1:0] sum_den_r;

  logic signed [W-1:0]    mul_a, mul_b, ad_s, bd_s;
  logic signed [NW-1:0]   prod;
  logic        [NW-1:0]   mag;
  logic                   u_gt;
  logic                   div_msb, div_ge;
  logic        [DW:0]     rem_sh, rem_diff;
  logic signed [NW:0]     sn;
  logic signed [XW-1:0]   sx;
  logic        [DXW-1:0]  dx;

  assign ad_s = signed'({1'b0, ad_r});
  assign bd_s = signed'({1'b0, bd_r});

  // One shared multiplier, its operands chosen by the step.
  always_comb begin
    mul_a = ad_s;
    mul_b = bd_s;
    case (cmd.op)
      DP_MUL0: begin
        mul_a = an_r;
        mul_b = bd_s;
      end
      DP_MUL1: begin
        mul_a = ad_s;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_s;
        mul_b = bd_s;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign mag  = top_r[NW-1] ? NW'(-top_r) : NW'(top_r);
  assign u_gt = u_r > {2'b00, v_r};

  assign div_msb  = (cmd.op == DP_DIVD) ? d_r[DW-1] : n_r[NW-1];
  assign rem_sh   = {rem_r, div_msb};
  assign div_ge   = rem_sh >= {1'b0, u_r[DW-1:0]};
  assign rem_diff = rem_sh - {1'b0, u_r[DW-1:0]};

  assign sn = neg_r ? -signed'({1'b0, n_r}) : signed'({1'b0, n_r});
  assign sx = XW'(sn);
  assign dx = DXW'(d_r);

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        an_r <= in_a_num;
        bn_r <= in_b_num;
        ad_r <= (in_a_den == '0) ? (W-1)'(1) : in_a_den;
        bd_r <= (in_b_den == '0) ? (W-1)'(1) : in_b_den;
      end
      DP_MUL0: prod_r <= prod;
      DP_MUL1: begin
        prod_r <= prod;
        top_r  <= prod_r;
      end
      DP_MUL2: begin
        prod_r <= prod;
        top_r  <= top_r + prod_r;
      end
      DP_ABS: begin
        u_r   <= mag;
        v_r   <= prod_r[DW-1:0];
        neg_r <= top_r[NW-1];
      end
      DP_STRIP: begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
      end
      DP_ZERO: begin
        n_r   <= '0;
        d_r   <= DW'(1);
        neg_r <= 1'b0;
      end
      DP_SAVE: begin
        n_r   <= u_r;
        d_r   <= v_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      DP_GCD: begin
        if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_gt) begin
          u_r <= u_r - {2'b00, v_r};
        end else begin
          v_r <= v_r - u_r[DW-1:0];
        end
      end
      DP_DIVN: begin
        n_r <= {n_r[NW-2:0], div_ge};
        // The last numerator step also clears the divider for the denominator.
        if (cmd.div_clr) begin
          rem_r <= '0;
          cnt_r <= '0;
        end else begin
          rem_r <= div_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
          cnt_r <= cnt_r + 1'b1;
        end
      end
      DP_DIVD: begin
        d_r   <= {d_r[DW-2:0], div_ge};
        rem_r <= div_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
      DP_OUT: begin
        sum_num_r <= sx[SUM_NUM_W-1:0];
        sum_den_r <= dx[SUM_DEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign sts.u_zero    = (u_r == '0);
  assign sts.both_even = !u_r[0] && !v_r[0];
  assign sts.gcd_eq    = (u_r == {2'b00, v_r});
  assign sts.g_one     = (u_r == NW'(1));
  assign sts.n_last    = (cnt_r == CW'(NW - 1));
  assign sts.d_last    = (cnt_r == CW'(DW - 1));

  assign out_sum_num = sum_num_r;
  assign out_sum_den = sum_den_r;

endmodule

// ----- rtl/rational_add_reduce.sv -----
// Each transaction runs through the load, three multiply steps, the magnitude step, one strip
// step per common factor of two, the binary gcd steps and, unless the gcd is one, a bit-serial
// division of the numerator and then the denominator; a zero sum skips the gcd and the division.
// One transaction at a time: the input stalls until the result is written to the output register.
// The output register lets a new transaction start while a result waits downstream.
// Reset: synchronous, active low; it clears the state machine and the output valid flag.
module rational_add_reduce
  import rar_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic        [OPERAND_WIDTH-2:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic        [OPERAND_WIDTH-2:0] in_b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SUM_NUM_W-1:0]     out_sum_num,
  output logic        [SUM_DEN_W-1:0]     out_sum_den
);

  // The controller sequences the work: three multiplies through one shared
  // multiplier build the unreduced numerator and denominator, the magnitude
  // is taken, common factors of two are stripped from both, and a binary gcd
  // finds the odd part of the divisor. Both stripped values are then divided
  // by that odd part, one quotient bit per cycle, unless it is one.
  rar_cmd_t cmd;
  rar_sts_t sts;

  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the gcd pair, the divider and the
  // output register. A zero sum is forced to 0/1 before any division.
  rar_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .cmd         (cmd),
    .sts         (sts),
    .out_sum_num (out_sum_num),
    .out_sum_den (out_sum_den)
  );

endmodule

// ----- rtl/rar_chk.sv -----
module rar_chk
  import rar_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [SUM_NUM_W-1:0] out_sum_num,
  input logic        [SUM_DEN_W-1:0] out_sum_den
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sum_num) && $stable(out_sum_den))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  // A reduced fraction never has both parts even.
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sum_num[0] || out_sum_den[0])
    else $error("result not reduced by two");

endmodule

bind rational_add_reduce rar_chk u_rar_chk (.*);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rar_pkg::*;

  // Operand widths at the default configuration of the block.
  localparam int NUM_W = 16;
  localparam int DEN_W = NUM_W - 1;

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1000;

  // The slowest transaction runs a full binary gcd plus
  // two bit-serial divisions.
  // The longest stretch without any transaction is the one long output
  // hold-off, plus one such transaction. The limit is several times that.
  localparam int HOLDOFF_AT     = 400;
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int IDLE_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 400;

  // Receiver behaviors. The receiver switches between them now and then.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  // One input transaction: two fractions as they appear on the ports.
  typedef struct packed {
    logic [NUM_W-1:0] a_num;
    logic [DEN_W-1:0] a_den;
    logic [NUM_W-1:0] b_num;
    logic [DEN_W-1:0] b_den;
  } frac_pair_t;

  // One result transaction: the reduced sum.
  typedef struct packed {
    logic [SUM_NUM_W-1:0] num;
    logic [SUM_DEN_W-1:0] den;
  } frac_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [NUM_W-1:0] in_a_num = '0;
  logic        [DEN_W-1:0] in_a_den = '0;
  logic signed [NUM_W-1:0] in_b_num = '0;
  logic        [DEN_W-1:0] in_b_den = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SUM_NUM_W-1:0] out_sum_num;
  logic        [SUM_DEN_W-1:0] out_sum_den;

  // Fraction pairs waiting to be offered, and reduced sums waiting to come out.
  frac_pair_t pending_pairs[$];
  frac_sum_t  expected_sums[$];

  int n_sent     = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_zero_sum = 0;
  int n_neg_sum  = 0;
  int n_den_zero = 0;
  int n_in_stall = 0;

  always #5 clk = ~clk;

  rational_add_reduce #(
    .OPERAND_WIDTH(NUM_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sum_num(out_sum_num),
    .out_sum_den(out_sum_den)
  );

  // Adds the two fractions exactly in 64 bits and reduces the sum to lowest
  // terms. A zero denominator counts as one, the sign stays on the numerator,
  // and a zero sum comes out as 0/1.
  function automatic frac_sum_t add_and_reduce(frac_pair_t p);
    longint          an;
    longint          bn;
    longint          top;
    longint unsigned ad;
    longint unsigned bd;
    longint unsigned bot;
    longint unsigned mag;
    longint unsigned x;
    longint unsigned y;
    longint unsigned r;
    logic            neg;
    frac_sum_t       s;
    an  = longint'($signed(p.a_num));
    bn  = longint'($signed(p.b_num));
    ad  = (p.a_den == '0) ? 64'd1 : 64'(p.a_den);
    bd  = (p.b_den == '0) ? 64'd1 : 64'(p.b_den);
    top = an * longint'(bd) + longint'(ad) * bn;
    bot = ad * bd;
    neg = (top < 0);
    mag = neg ? (64'd0 - longint'(top)) : longint'(top);
    if (mag == 0) begin
      s.num = '0;
      s.den = SUM_DEN_W'(1);
      return s;
    end
    // Euclid on the magnitude and the denominator.
    x = mag;
    y = bot;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mag = mag / x;
    bot = bot / x;
    s.num = SUM_NUM_W'(neg ? (64'd0 - mag) : mag);
    s.den = SUM_DEN_W'(bot);
    return s;
  endfunction

  task automatic add_pair(input int an, input int ad, input int bn, input int bd);
    frac_pair_t p;
    p.a_num = NUM_W'(an);
    p.a_den = DEN_W'(ad);
    p.b_num = NUM_W'(bn);
    p.b_den = DEN_W'(bd);
    pending_pairs.push_back(p);
  endtask

  // Draws one random fraction pair. Four draws in ten cover the full field
  // ranges, while the rest steer toward small values, zero sums, shared factors,
  // powers of two, zero denominators and the extreme values.
  task automatic add_random_pair();
    int          kind;
    int          f;
    int          sh;
    int          ext_num[5];
    int          ext_den[4];
    frac_pair_t  p;
    ext_num = '{-32768, -1, 0, 1, 32767};
    ext_den = '{0, 1, 16384, 32767};
    kind = $urandom_range(0, 9);
    p.a_num = NUM_W'($urandom);
    p.a_den = DEN_W'($urandom);
    p.b_num = NUM_W'($urandom);
    p.b_den = DEN_W'($urandom);
    case (kind)
      4: begin
        p.a_num = NUM_W'(int'($urandom_range(0, 40)) - 20);
        p.b_num = NUM_W'(int'($urandom_range(0, 40)) - 20);
        p.a_den = DEN_W'($urandom_range(0, 12));
        p.b_den = DEN_W'($urandom_range(0, 12));
      end
      5: begin
        // Opposite fractions, so the sum is zero unless the numerator is -32768.
        p.b_num = -p.a_num;
        p.b_den = p.a_den;
      end
      6: begin
        sh = $urandom_range(0, 14);
        p.a_num = NUM_W'($urandom_range(0, 31)) << $urandom_range(0, 10);
        p.b_num = NUM_W'($urandom_range(0, 31)) << $urandom_range(0, 10);
        if ($urandom_range(0, 1) == 1) p.a_num = -p.a_num;
        p.a_den = DEN_W'(1) << sh;
        p.b_den = DEN_W'(1) << $urandom_range(0, 14);
      end
      7: begin
        // Both denominators and numerators share a factor.
        f = $urandom_range(2, 180);
        p.a_den = DEN_W'(f * $urandom_range(1, 180));
        p.b_den = DEN_W'(f * $urandom_range(1, 180));
        p.a_num = NUM_W'(f * (int'($urandom_range(0, 360)) - 180));
        p.b_num = NUM_W'(f * (int'($urandom_range(0, 360)) - 180));
      end
      8: begin
        if ($urandom_range(0, 2) != 1) p.a_den = '0;
        if ($urandom_range(0, 2) != 0) p.b_den = '0;
      end
      9: begin
        p.a_num = NUM_W'(ext_num[$urandom_range(0, 4)]);
        p.b_num = NUM_W'(ext_num[$urandom_range(0, 4)]);
        p.a_den = DEN_W'(ext_den[$urandom_range(0, 3)]);
        p.b_den = DEN_W'(ext_den[$urandom_range(0, 3)]);
      end
      default: ;
    endcase
    pending_pairs.push_back(p);
  endtask

  // Sender. It offers the next fraction pair once the previous one has been
  // taken, in bursts of random length separated by random gaps. A pair that
  // is stalled stays on the ports unchanged.
  int         burst_left = 0;
  int         gap_left   = 0;
  frac_pair_t next_pair;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || n_accepted == n_sent)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        next_pair = pending_pairs.pop_front();
        in_a_num <= next_pair.a_num;
        in_a_den <= next_pair.a_den;
        in_b_num <= next_pair.b_num;
        in_b_den <= next_pair.b_den;
        in_valid <= 1'b1;
        n_sent   <= n_sent + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // About a quarter of the bursts run straight into the next one.
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. It cycles through stall modes of random duration. Once, after
  // a few hundred transactions, it holds off for a long stretch while the
  // sender keeps offering, so the block fills up and stalls its input.
  stall_mode_t stall_mode    = STALL_NONE;
  int          mode_left     = 0;
  int          mode_phase    = 0;
  int          holdoff_left  = 0;
  logic        holdoff_done  = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else if (!holdoff_done && n_accepted >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES - 1;
      out_stall    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(64, 512);
      end else begin
        mode_left = mode_left - 1;
      end
      mode_phase = mode_phase + 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: out_stall <= ((mode_phase % 7) < 3);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 7) != 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor. Results are checked against the oldest outstanding sum first,
  // then an accepted input transaction gets its expected sum queued. A result
  // can never belong to an input taken at the same edge.
  frac_pair_t taken_pair;
  frac_sum_t  want_sum;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          $error("result %0d/%0d arrived with no transaction outstanding",
                 out_sum_num, out_sum_den);
          n_errors = n_errors + 1;
        end else begin
          want_sum = expected_sums.pop_front();
          if (out_sum_num !== want_sum.num) begin
            $error("sum_num mismatch: expected %0d, got %0d",
                   $signed(want_sum.num), out_sum_num);
            n_errors = n_errors + 1;
          end
          if (out_sum_den !== want_sum.den) begin
            $error("sum_den mismatch: expected %0d, got %0d", want_sum.den, out_sum_den);
            n_errors = n_errors + 1;
          end
          n_checked = n_checked + 1;
        end
      end
      if (in_valid && !in_stall) begin
        taken_pair = '{a_num: in_a_num, a_den: in_a_den, b_num: in_b_num, b_den: in_b_den};
        want_sum   = add_and_reduce(taken_pair);
        expected_sums.push_back(want_sum);
        n_accepted <= n_accepted + 1;
        if (want_sum.num == '0) n_zero_sum = n_zero_sum + 1;
        if (want_sum.num[SUM_NUM_W-1]) n_neg_sum = n_neg_sum + 1;
        if (in_a_den == '0 || in_b_den == '0) n_den_zero = n_den_zero + 1;
      end
      if (in_valid && in_stall) n_in_stall = n_in_stall + 1;
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed pairs: zero sums, zero denominators, extreme numerators and
    // denominators, negative sums, coprime and highly reducible sums.
    add_pair(0, 0, 0, 0);
    add_pair(1, 2, -1, 2);
    add_pair(32767, 32767, 32767, 32767);
    add_pair(-32768, 32767, -32768, 32767);
    add_pair(-32768, 1, -32768, 1);
    add_pair(32767, 1, 32767, 1);
    add_pair(-32768, 32767, 32767, 32766);
    add_pair(1, 32767, 1, 32766);
    add_pair(3, 4, 5, 12);
    add_pair(-7, 0, 3, 0);
    add_pair(1, 3, -1, 2);
    add_pair(6, 8, 10, 16);
    add_pair(16384, 16384, -16384, 16384);
    add_pair(-1, 32767, 0, 5);
    add_pair(0, 32767, 0, 32767);
    add_pair(32767, 2, -32768, 2);
    add_pair(12345, 0, -12345, 1);
    add_pair(-32768, 16384, 16384, 8192);
    add_pair(1, 1, 1, 1);
    add_pair(21845, 10922, -10923, 21845);
    add_pair(-32768, 0, 32767, 32767);
    add_pair(-1, 1, -1, 1);
    repeat (RANDOM_ITEMS) add_random_pair();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || n_accepted != n_sent) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d reduced sums: %0d zero, %0d negative, %0d with a zero denominator.",
             n_checked, n_zero_sum, n_neg_sum, n_den_zero);
    $display("Input was stalled in %0d cycles, including one output hold-off of %0d cycles.",
             n_in_stall, HOLDOFF_CYCLES);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rar_pkg.sv
rtl/rar_ctrl.sv
rtl/rar_dp.sv
rtl/rational_add_reduce.sv
rtl/rar_chk.sv
tb/sv/tb_top.sv
